/* sv/rlcm_pkg.sv */
// Shared types and constants for the range LCM segment tree block.
// Used by the combine unit, datapath, controller and top level.
`timescale 1ns / 1ps

package rlcm_pkg;

   // Tree geometry: leaves sit at MAX_ELEMENTS + index.
   localparam int MAX_ELEMENTS = 1024;
   localparam int NODE_COUNT   = 2 * MAX_ELEMENTS;
   localparam int NODE_W       = $clog2(NODE_COUNT);
   localparam int PTR_W        = NODE_W + 1;
   localparam int POS_W        = 10;
   localparam int CNT_W        = 11;
   localparam int ELEM_W       = 31;
   localparam int VAL_W        = 64;

   // Request codes.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  range_end;
      logic [ELEM_W-1:0] element_value;
   } req_beat_type;

   typedef struct packed {
      logic [VAL_W-1:0] lcm_value;
      logic             overflow;
   } rsp_beat_type;

   // One tree node: value plus sticky overflow flag.
   typedef struct packed {
      logic             ov;
      logic [VAL_W-1:0] val;
   } node_type;

   localparam node_type NODE_ONE = '{ov: 1'b0, val: 64'd1};

   // Memory read address selection.
   typedef enum logic [1:0] {
      RD_LEFT,
      RD_RIGHT,
      RD_LPTR,
      RD_RPTR
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       clr_wr;
      logic       capture;
      logic       wr_leaf;
      logic       wr_node;
      rd_sel_type rd_sel;
      logic       ld_a_mem;
      logic       ld_b_mem;
      logic       ld_a_acc;
      logic       comb_start;
      logic       acc_take;
      logic       idx_shift;
      logic       q_init;
      logic       l_inc;
      logic       r_dec;
      logic       lr_shift;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_write;
      logic in_range;
      logic q_empty;
      logic idx_zero;
      logic l_lt_r;
      logic l_odd;
      logic r_odd;
      logic clr_last;
      logic comb_done;
   } status_type;

endpackage

/* sv/rlcm_comb.sv */
// Iterative LCM combine unit: binary GCD, restoring divide, shift-add multiply.
// Depends on rlcm_pkg for widths and the node type.
`timescale 1ns / 1ps

module rlcm_comb (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rlcm_pkg::node_type opa,
   input  rlcm_pkg::node_type opb,
   output logic              done,
   output rlcm_pkg::node_type res
);
   import rlcm_pkg::*;

   typedef enum logic [1:0] {
      C_IDLE,
      C_GCD,
      C_DIV,
      C_MUL
   } comb_state_type;

   comb_state_type   st_ff;
   logic             done_ff;
   logic [VAL_W-1:0] x_ff;
   logic [VAL_W-1:0] y_ff;
   logic [5:0]       k_ff;
   logic [VAL_W-1:0] g_ff;
   logic [VAL_W-1:0] b_ff;
   logic [VAL_W-1:0] rem_ff;
   logic [VAL_W-1:0] dvd_ff;
   logic [2*VAL_W-1:0] prod_ff;
   logic [5:0]       cnt_ff;
   node_type         res_ff;

   logic [VAL_W:0]     rem_sh;
   logic               rem_ge;
   logic [VAL_W:0]     rem_sub;
   logic [2*VAL_W-1:0] prod_sh;

   // One restoring divide step and one shift-add multiply step.
   assign rem_sh  = {rem_ff, dvd_ff[VAL_W-1]};
   assign rem_ge  = rem_sh >= {1'b0, g_ff};
   assign rem_sub = rem_sh - {1'b0, g_ff};
   assign prod_sh = {prod_ff[2*VAL_W-2:0], 1'b0}
                  + (dvd_ff[VAL_W-1] ? {{VAL_W{1'b0}}, b_ff} : {(2*VAL_W){1'b0}});

   // Sequencer and working registers.
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         st_ff   <= C_IDLE;
      end else begin
         unique case (st_ff)
            C_IDLE: begin
               if (start) begin
                  x_ff   <= opa.val;
                  y_ff   <= opb.val;
                  b_ff   <= opb.val;
                  dvd_ff <= opa.val;
                  k_ff   <= '0;
                  if (opa.val == '0 || opb.val == '0) begin
                     // A zero element forces the result to zero.
                     res_ff  <= '{ov: 1'b0, val: '0};
                     done_ff <= 1'b1;
                  end else if (opa.ov || opb.ov) begin
                     res_ff  <= '{ov: 1'b1, val: '1};
                     done_ff <= 1'b1;
                  end else begin
                     st_ff <= C_GCD;
                  end
               end
            end
            C_GCD: begin
               if (x_ff == y_ff) begin
                  g_ff   <= x_ff << k_ff;
                  rem_ff <= '0;
                  cnt_ff <= '1;
                  st_ff  <= C_DIV;
               end else if (!x_ff[0] && !y_ff[0]) begin
                  x_ff <= x_ff >> 1;
                  y_ff <= y_ff >> 1;
                  k_ff <= k_ff + 6'd1;
               end else if (!x_ff[0]) begin
                  x_ff <= x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_ff <= y_ff >> 1;
               end else if (x_ff > y_ff) begin
                  x_ff <= x_ff - y_ff;
               end else begin
                  y_ff <= y_ff - x_ff;
               end
            end
            C_DIV: begin
               rem_ff <= rem_ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
               dvd_ff <= {dvd_ff[VAL_W-2:0], rem_ge};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == '0) begin
                  prod_ff <= '0;
                  st_ff   <= C_MUL;
               end
            end
            C_MUL: begin
               prod_ff <= prod_sh;
               dvd_ff  <= {dvd_ff[VAL_W-2:0], 1'b0};
               cnt_ff  <= cnt_ff - 6'd1;
               if (cnt_ff == '0) begin
                  if (|prod_sh[2*VAL_W-1:VAL_W]) begin
                     res_ff <= '{ov: 1'b1, val: '1};
                  end else begin
                     res_ff <= '{ov: 1'b0, val: prod_sh[VAL_W-1:0]};
                  end
                  done_ff <= 1'b1;
                  st_ff   <= C_IDLE;
               end
            end
            default: st_ff <= C_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

/* sv/rlcm_dp.sv */
// Datapath: node memory, request and pointer registers, count register, combine unit.
// Depends on rlcm_pkg and rlcm_comb.
`timescale 1ns / 1ps

module rlcm_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  rlcm_pkg::cmd_type       cmd,
   output rlcm_pkg::status_type    status,
   input  rlcm_pkg::req_beat_type  req_data,
   output rlcm_pkg::rsp_beat_type  rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata
);
   import rlcm_pkg::*;

   node_type          mem [NODE_COUNT];
   node_type          rdata_ff;
   req_beat_type      req_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NODE_W-1:0] clr_ff;
   logic [NODE_W-1:0] idx_ff;
   logic [PTR_W-1:0]  l_ff;
   logic [PTR_W-1:0]  r_ff;
   node_type          opa_ff;
   node_type          opb_ff;
   node_type          acc_ff;

   logic [CNT_W-1:0]  n_eff;
   logic [CNT_W-1:0]  lim;
   logic [CNT_W-1:0]  end_c;
   logic              mem_we;
   logic [NODE_W-1:0] wr_addr;
   node_type          wr_data;
   logic [NODE_W-1:0] rd_addr;
   logic              comb_done;
   node_type          comb_res;

   // Configuration register; only register zero exists.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(MAX_ELEMENTS);
      end else if (psel && penable && pwrite && !paddr[2]) begin
         cnt_ff <= pwdata[CNT_W-1:0];
      end
   end

   assign prdata = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, cnt_ff};

   // Count in effect and clipped query range.
   assign n_eff = (cnt_ff > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : cnt_ff;
   assign lim   = n_eff - CNT_W'(1);
   assign end_c = ({1'b0, req_ff.range_end} > lim) ? lim : {1'b0, req_ff.range_end};

   // Memory write port: clearing pass, leaf write or node update.
   always_comb begin
      mem_we  = 1'b0;
      wr_addr = clr_ff;
      wr_data = NODE_ONE;
      if (cmd.clr_wr) begin
         mem_we = 1'b1;
      end else if (cmd.wr_leaf) begin
         mem_we  = 1'b1;
         wr_addr = NODE_W'(MAX_ELEMENTS) + NODE_W'(req_ff.position);
         wr_data = '{ov: 1'b0, val: {{(VAL_W-ELEM_W){1'b0}}, req_ff.element_value}};
      end else if (cmd.wr_node) begin
         mem_we  = 1'b1;
         wr_addr = idx_ff;
         wr_data = comb_res;
      end
   end

   // Memory read port address.
   always_comb begin
      case (cmd.rd_sel)
         RD_LEFT:  rd_addr = {idx_ff[NODE_W-2:0], 1'b0};
         RD_RIGHT: rd_addr = {idx_ff[NODE_W-2:0], 1'b1};
         RD_LPTR:  rd_addr = l_ff[NODE_W-1:0];
         RD_RPTR:  rd_addr = r_ff[NODE_W-1:0];
         default:  rd_addr = '0;
      endcase
   end

   // Node memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + NODE_W'(1);
      end
   end

   // Request, pointers, operands and accumulator.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
         acc_ff <= NODE_ONE;
      end
      if (cmd.wr_leaf) begin
         idx_ff <= (NODE_W'(MAX_ELEMENTS) + NODE_W'(req_ff.position)) >> 1;
      end else if (cmd.idx_shift) begin
         idx_ff <= idx_ff >> 1;
      end
      if (cmd.q_init) begin
         l_ff <= PTR_W'(MAX_ELEMENTS) + PTR_W'(req_ff.position);
         r_ff <= PTR_W'(MAX_ELEMENTS) + PTR_W'(end_c) + PTR_W'(1);
      end else begin
         if (cmd.l_inc) begin
            l_ff <= l_ff + PTR_W'(1);
         end else if (cmd.lr_shift) begin
            l_ff <= l_ff >> 1;
         end
         if (cmd.r_dec) begin
            r_ff <= r_ff - PTR_W'(1);
         end else if (cmd.lr_shift) begin
            r_ff <= r_ff >> 1;
         end
      end
      if (cmd.ld_a_mem) begin
         opa_ff <= rdata_ff;
      end else if (cmd.ld_a_acc) begin
         opa_ff <= acc_ff;
      end
      if (cmd.ld_b_mem) begin
         opb_ff <= rdata_ff;
      end
      if (cmd.acc_take) begin
         acc_ff <= comb_res;
      end
   end

   rlcm_comb u_comb (
      .clock (clock),
      .reset (reset),
      .start (cmd.comb_start),
      .opa   (opa_ff),
      .opb   (opb_ff),
      .done  (comb_done),
      .res   (comb_res)
   );

   // Status back to the controller.
   always_comb begin
      status.is_write  = (req_ff.req_type == REQ_WRITE);
      status.in_range  = ({1'b0, req_ff.position} < n_eff);
      status.q_empty   = (n_eff == '0) || ({1'b0, req_ff.position} > end_c);
      status.idx_zero  = (idx_ff == '0);
      status.l_lt_r    = (l_ff < r_ff);
      status.l_odd     = l_ff[0];
      status.r_odd     = r_ff[0];
      status.clr_last  = (clr_ff == '1);
      status.comb_done = comb_done;
   end

   assign rsp_data.lcm_value = acc_ff.val;
   assign rsp_data.overflow  = acc_ff.ov;

endmodule

/* sv/rlcm_ctrl.sv */
// Controller state machine: clearing pass, tree update walk and range query walk.
// Depends on rlcm_pkg for the command and status structs.
`timescale 1ns / 1ps

module rlcm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output rlcm_pkg::cmd_type    cmd,
   input  rlcm_pkg::status_type status
);
   import rlcm_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DISP,
      S_W_TEST,
      S_W_RDL,
      S_W_RDR,
      S_W_GETR,
      S_W_GO,
      S_W_COMB,
      S_Q_TEST,
      S_Q_LRD,
      S_Q_LGET,
      S_Q_LGO,
      S_Q_LCOMB,
      S_Q_RCHK,
      S_Q_RRD,
      S_Q_RGET,
      S_Q_RGO,
      S_Q_RCOMB
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           busy_ff;
   logic           rsp_valid_ff;
   logic           resp_go;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      resp_go  = 1'b0;
      cmd      = '0;
      cmd.rd_sel = RD_LEFT;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            if (status.is_write) begin
               if (status.in_range) begin
                  cmd.wr_leaf = 1'b1;
                  state_in    = S_W_TEST;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (status.q_empty) begin
               resp_go  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.q_init = 1'b1;
               state_in   = S_Q_TEST;
            end
         end
         S_W_TEST: begin
            state_in = status.idx_zero ? S_IDLE : S_W_RDL;
         end
         S_W_RDL: begin
            cmd.rd_sel = RD_LEFT;
            state_in   = S_W_RDR;
         end
         S_W_RDR: begin
            cmd.rd_sel   = RD_RIGHT;
            cmd.ld_a_mem = 1'b1;
            state_in     = S_W_GETR;
         end
         S_W_GETR: begin
            cmd.ld_b_mem = 1'b1;
            state_in     = S_W_GO;
         end
         S_W_GO: begin
            cmd.comb_start = 1'b1;
            state_in       = S_W_COMB;
         end
         S_W_COMB: begin
            if (status.comb_done) begin
               cmd.wr_node   = 1'b1;
               cmd.idx_shift = 1'b1;
               state_in      = S_W_TEST;
            end
         end
         S_Q_TEST: begin
            if (!status.l_lt_r) begin
               resp_go  = 1'b1;
               state_in = S_IDLE;
            end else if (status.l_odd) begin
               state_in = S_Q_LRD;
            end else begin
               state_in = S_Q_RCHK;
            end
         end
         S_Q_LRD: begin
            cmd.rd_sel = RD_LPTR;
            state_in   = S_Q_LGET;
         end
         S_Q_LGET: begin
            cmd.ld_a_acc = 1'b1;
            cmd.ld_b_mem = 1'b1;
            cmd.l_inc    = 1'b1;
            state_in     = S_Q_LGO;
         end
         S_Q_LGO: begin
            cmd.comb_start = 1'b1;
            state_in       = S_Q_LCOMB;
         end
         S_Q_LCOMB: begin
            if (status.comb_done) begin
               cmd.acc_take = 1'b1;
               state_in     = S_Q_RCHK;
            end
         end
         S_Q_RCHK: begin
            if (status.r_odd) begin
               cmd.r_dec = 1'b1;
               state_in  = S_Q_RRD;
            end else begin
               cmd.lr_shift = 1'b1;
               state_in     = S_Q_TEST;
            end
         end
         S_Q_RRD: begin
            cmd.rd_sel = RD_RPTR;
            state_in   = S_Q_RGET;
         end
         S_Q_RGET: begin
            cmd.ld_a_acc = 1'b1;
            cmd.ld_b_mem = 1'b1;
            state_in     = S_Q_RGO;
         end
         S_Q_RGO: begin
            cmd.comb_start = 1'b1;
            state_in       = S_Q_RCOMB;
         end
         S_Q_RCOMB: begin
            if (status.comb_done) begin
               cmd.acc_take = 1'b1;
               cmd.lr_shift = 1'b1;
               state_in     = S_Q_TEST;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= resp_go;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   // An accepted beat makes the block busy on the next cycle.
   a_capture_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> busy_ff)
      else $error("block not busy after accepting a request");

   // A result is only presented while the block is idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("result strobe while busy");

   // A result strobe lasts exactly one cycle.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

endmodule

/* sv/range_lcm_segment_tree.sv */
// Top level of the range LCM segment tree block.
// Depends on rlcm_pkg, rlcm_ctrl and rlcm_dp.
`timescale 1ns / 1ps

// Usage:
// A request beat (req_data) is accepted at a rising edge where start is high
// and busy is low. A write beat sets one element and walks its path to the
// root; it produces no result. A query beat produces one result beat on
// rsp_data, marked by rsp_valid for exactly one cycle. The receiver cannot
// stall; it must take the beat in that cycle.
// element_count is written through the APB-style port at byte address 0. The
// user must write it only while the block is idle; the block itself does not
// enforce this. pready is always high. After reset the block runs a clearing
// pass over all 2048 tree nodes, holding busy high until it ends; configuration
// writes are still taken. One item is in flight at a time. Each node combine
// runs in a shared iterative unit: binary GCD, then restoring divide, then
// shift-add multiply, plus memory access and control. A write does 10
// combines, a query up to about 20; an ignored write or empty query does none.
module range_lcm_segment_tree (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rlcm_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   output rlcm_pkg::rsp_beat_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import rlcm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   rlcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Storage and arithmetic.
   rlcm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata)
   );

   assign pready = 1'b1;

endmodule
